// File: rtl/pbl_pkg.sv
package pbl_pkg;

  localparam int unsigned MaxFramesDef = 64;
  localparam int unsigned TableBitsDef = 10;
  localparam int unsigned PageBitsDef  = 32;
  localparam int unsigned PinBitsDef   = 8;
  localparam int unsigned CfgBits      = 7;
  localparam int unsigned RelBits      = 6;
  localparam int unsigned FuncBits     = 2;

  localparam logic [FuncBits-1:0] FuncRead  = 2'd0;
  localparam logic [FuncBits-1:0] FuncWrite = 2'd1;
  localparam logic [FuncBits-1:0] FuncUnpin = 2'd2;

endpackage

// File: rtl/pbl_front.sv
module pbl_front import pbl_pkg::*; #(
  parameter int unsigned TableBits = TableBitsDef,
  parameter int unsigned PageBits  = PageBitsDef,
  parameter int unsigned QW        = FuncBits + TableBits + PageBits + RelBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  logic [QW-1:0]       item_i,
  output logic                q_valid_o,
  output logic [QW-1:0]       q_item_o,
  input  logic                q_take_i
);

  // two-entry queue between the input and the tag engine
  logic [QW-1:0] mem_q [2];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;
  logic          do_push, do_pop;

  assign full_o    = cnt_q[1];
  assign do_push   = push_i && !full_o;
  assign q_valid_o = cnt_q != 2'd0;
  assign do_pop    = q_take_i && q_valid_o;
  assign q_item_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wp_q <= !wp_q;
      if (do_pop)  rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// File: rtl/pbl_back.sv
module pbl_back import pbl_pkg::*; #(
  parameter int unsigned MaxFrames = MaxFramesDef,
  parameter int unsigned TableBits = TableBitsDef,
  parameter int unsigned PageBits  = PageBitsDef,
  parameter int unsigned PinBits   = PinBitsDef,
  parameter int unsigned FW        = $clog2(MaxFrames),
  parameter int unsigned QW        = FuncBits + TableBits + PageBits + RelBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgBits-1:0]   cfg_wdata_i,
  input  logic                 q_valid_i,
  input  logic [QW-1:0]        q_item_i,
  output logic                 q_take_o,
  output logic                 empty_o,
  input  logic                 pop_i,
  output logic [RelBits-1:0]   frame_index_o,
  output logic                 hit_o,
  output logic                 bypass_o,
  output logic                 fill_needed_o,
  output logic                 writeback_needed_o,
  output logic [TableBits-1:0] writeback_table_o,
  output logic [PageBits-1:0]  writeback_page_o
);

  localparam int unsigned CW = $clog2(MaxFrames + 1);
  localparam logic [PinBits-1:0] PinMax = {PinBits{1'b1}};

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StUpd  = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  logic [1:0] st_q, st_d;

  logic [CfgBits-1:0] cfg_q;

  logic [MaxFrames-1:0] valid_q, dirty_q;
  logic [TableBits-1:0] tab_q  [MaxFrames];
  logic [PageBits-1:0]  page_q [MaxFrames];
  logic [PinBits-1:0]   pin_q  [MaxFrames];
  logic [FW-1:0]        rank_q [MaxFrames];

  logic [FuncBits-1:0]  func_q;
  logic [TableBits-1:0] rtab_q;
  logic [PageBits-1:0]  rpage_q;
  logic [RelBits-1:0]   rel_q;

  // frames in the active window
  logic [CW-1:0] lim;
  logic [MaxFrames-1:0] act;
  always_comb begin
    if (cfg_q == '0) lim = CW'(1);
    else if ({1'b0, cfg_q} > (CfgBits+1)'(MaxFrames)) lim = CW'(MaxFrames);
    else lim = CW'(cfg_q);
    for (int i = 0; i < MaxFrames; i++) act[i] = CW'(i) < lim;
  end

  // scan stage: match, empty and unpinned vectors, registered
  logic [MaxFrames-1:0] mvec_q, evec_q, uvec_q;
  logic [CW-1:0] vcnt_q;

  // priority pick of lowest set bit
  function automatic logic [FW:0] first_set(input logic [MaxFrames-1:0] v);
    logic [FW:0] r;
    r = '0;
    for (int i = MaxFrames - 1; i >= 0; i--) begin
      if (v[i]) r = {1'b1, FW'(i)};
    end
    return r;
  endfunction

  logic [FW:0] hit_s, emp_s;
  assign hit_s = first_set(mvec_q);
  assign emp_s = first_set(evec_q);

  // least recent unpinned: ranks are distinct among valid frames
  // reduce pairwise in a tree; leaves sit at MaxFrames .. 2*MaxFrames-1
  logic          lr_ok   [2*MaxFrames];
  logic [FW-1:0] lr_idx  [2*MaxFrames];
  logic [FW-1:0] lr_rank [2*MaxFrames];
  logic          lru_ok;
  logic [FW-1:0] lru_f;
  always_comb begin
    for (int i = 0; i < MaxFrames; i++) begin
      lr_ok[MaxFrames+i]   = uvec_q[i];
      lr_idx[MaxFrames+i]  = FW'(i);
      lr_rank[MaxFrames+i] = rank_q[i];
    end
    for (int n = MaxFrames - 1; n >= 1; n--) begin
      if (lr_ok[2*n] && (!lr_ok[2*n+1] || lr_rank[2*n] <= lr_rank[2*n+1])) begin
        lr_ok[n]   = lr_ok[2*n];
        lr_idx[n]  = lr_idx[2*n];
        lr_rank[n] = lr_rank[2*n];
      end else begin
        lr_ok[n]   = lr_ok[2*n+1];
        lr_idx[n]  = lr_idx[2*n+1];
        lr_rank[n] = lr_rank[2*n+1];
      end
    end
    lr_ok[0]   = 1'b0;
    lr_idx[0]  = '0;
    lr_rank[0] = '0;
    lru_ok = lr_ok[1];
    lru_f  = lr_idx[1];
  end

  logic          fnd;
  logic          is_hit;
  logic          is_evict;
  logic [FW-1:0] sel;
  always_comb begin
    is_hit   = hit_s[FW];
    is_evict = 1'b0;
    if (hit_s[FW]) begin
      sel = hit_s[FW-1:0]; fnd = 1'b1;
    end else if (emp_s[FW]) begin
      sel = emp_s[FW-1:0]; fnd = 1'b1;
    end else begin
      sel = lru_f; fnd = lru_ok; is_evict = lru_ok;
    end
  end

  // result register
  logic                 ovalid_q;
  logic [RelBits-1:0]   o_idx_q;
  logic                 o_hit_q, o_byp_q, o_fill_q, o_wb_q;
  logic [TableBits-1:0] o_wt_q;
  logic [PageBits-1:0]  o_wp_q;

  assign empty_o            = !ovalid_q;
  assign frame_index_o      = o_idx_q;
  assign hit_o              = o_hit_q;
  assign bypass_o           = o_byp_q;
  assign fill_needed_o      = o_fill_q;
  assign writeback_needed_o = o_wb_q;
  assign writeback_table_o  = o_wt_q;
  assign writeback_page_o   = o_wp_q;

  assign q_take_o = (st_q == StIdle) && q_valid_i;

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle: if (q_valid_i) st_d = StScan;
      StScan: st_d = StUpd;
      StUpd:  st_d = StOut;
      StOut:  if (!ovalid_q || pop_i) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= StIdle;
      cfg_q <= CfgBits'(64);
    end else begin
      st_q <= st_d;
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
    end
  end

  // request capture and scan
  always_ff @(posedge clk_i) begin
    if (q_take_o) begin
      {func_q, rtab_q, rpage_q, rel_q} <= q_item_i;
    end
    if (st_q == StScan) begin
      for (int i = 0; i < MaxFrames; i++) begin
        mvec_q[i] <= act[i] && valid_q[i] && tab_q[i] == rtab_q && page_q[i] == rpage_q;
        evec_q[i] <= act[i] && !valid_q[i];
        uvec_q[i] <= act[i] && valid_q[i] && pin_q[i] == '0;
      end
      vcnt_q <= CW'($countones(valid_q));
    end
  end

  // update stage
  logic upd, is_acc;
  assign upd    = st_q == StUpd;
  assign is_acc = func_q == FuncRead || func_q == FuncWrite;

  logic [PinBits-1:0] pin_base;
  assign pin_base = is_hit ? pin_q[sel] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      dirty_q <= '0;
      for (int i = 0; i < MaxFrames; i++) pin_q[i] <= '0;
    end else if (upd) begin
      if (func_q == FuncUnpin) begin
        if (CW'(rel_q) < lim && RelBits'(MaxFrames-1) >= rel_q
            && valid_q[FW'(rel_q)] && pin_q[FW'(rel_q)] != '0)
          pin_q[FW'(rel_q)] <= pin_q[FW'(rel_q)] - 1'b1;
      end else if (is_acc && fnd) begin
        valid_q[sel] <= 1'b1;
        // a read hit keeps the dirty bit; a fresh page starts clean
        if (func_q == FuncWrite) dirty_q[sel] <= 1'b1;
        else if (!is_hit) dirty_q[sel] <= 1'b0;
        if (func_q == FuncRead)
          pin_q[sel] <= (pin_base == PinMax) ? pin_base : pin_base + 1'b1;
        else
          pin_q[sel] <= (pin_base == '0) ? pin_base : pin_base - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd && is_acc && fnd) begin
      if (!is_hit) begin
        tab_q[sel]  <= rtab_q;
        page_q[sel] <= rpage_q;
      end
      if (!valid_q[sel]) begin
        rank_q[sel] <= FW'(vcnt_q);
      end else begin
        for (int g = 0; g < MaxFrames; g++)
          if (valid_q[g] && rank_q[g] > rank_q[sel]) rank_q[g] <= rank_q[g] - 1'b1;
        rank_q[sel] <= FW'(vcnt_q - 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (upd) begin
      ovalid_q <= 1'b1;
    end else if (pop_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd) begin
      o_idx_q  <= '0;
      o_hit_q  <= 1'b0;
      o_byp_q  <= 1'b0;
      o_fill_q <= 1'b0;
      o_wb_q   <= 1'b0;
      o_wt_q   <= '0;
      o_wp_q   <= '0;
      if (func_q == FuncUnpin) begin
        o_idx_q <= rel_q;
      end else if (is_acc) begin
        if (!fnd) begin
          o_byp_q <= 1'b1;
        end else begin
          o_idx_q  <= RelBits'(sel);
          o_hit_q  <= is_hit;
          o_fill_q <= !is_hit;
          if (is_evict && dirty_q[sel]) begin
            o_wb_q <= 1'b1;
            o_wt_q <= tab_q[sel];
            o_wp_q <= page_q[sel];
          end
        end
      end
    end
  end

endmodule

// File: rtl/page_buffer_pool_lru.sv
// Channel   Handshake             Payload
// input     push / full           func_i, table_tag_i, page_number_i, release_frame_i
// result    pop / empty           frame_index_o .. writeback_page_o
// config    cfg_we_i              cfg_wdata_i (frames_in_use)
//
// A request passes through the tag engine in order: dequeue, parallel scan of all
// frames, update of tags, pins and ranks, then the result register drains.
// A two-entry input queue keeps taking transfers while the engine works.
// Reset clears valid, dirty and pin state at once; no clearing pass.
// A full result register stalls the engine until the result is popped.
module page_buffer_pool_lru import pbl_pkg::*; #(
  parameter int unsigned MaxFrames = MaxFramesDef,
  parameter int unsigned TableBits = TableBitsDef,
  parameter int unsigned PageBits  = PageBitsDef,
  parameter int unsigned PinBits   = PinBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  logic [FuncBits-1:0]  func_i,
  input  logic [TableBits-1:0] table_tag_i,
  input  logic [PageBits-1:0]  page_number_i,
  input  logic [RelBits-1:0]   release_frame_i,
  output logic                 empty,
  input  logic                 pop,
  output logic [RelBits-1:0]   frame_index_o,
  output logic                 hit_o,
  output logic                 bypass_o,
  output logic                 fill_needed_o,
  output logic                 writeback_needed_o,
  output logic [TableBits-1:0] writeback_table_o,
  output logic [PageBits-1:0]  writeback_page_o,
  input  logic                 cfg_we_i,
  input  logic [CfgBits-1:0]   cfg_wdata_i
);

  localparam int unsigned QW = FuncBits + TableBits + PageBits + RelBits;

  logic          q_valid, q_take;
  logic [QW-1:0] q_item;

  // front: hold requests in a short queue
  pbl_front #(.TableBits(TableBits), .PageBits(PageBits)) u_front (
    .clk_i, .rst_ni,
    .push_i    (push),
    .full_o    (full),
    .item_i    ({func_i, table_tag_i, page_number_i, release_frame_i}),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_take_i  (q_take)
  );

  // back: tag engine and result register
  pbl_back #(
    .MaxFrames(MaxFrames), .TableBits(TableBits),
    .PageBits(PageBits), .PinBits(PinBits)
  ) u_back (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_wdata_i,
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_take_o  (q_take),
    .empty_o   (empty),
    .pop_i     (pop),
    .frame_index_o, .hit_o, .bypass_o, .fill_needed_o,
    .writeback_needed_o, .writeback_table_o, .writeback_page_o
  );

endmodule

// File: rtl/pbl_checker.sv
module pbl_checker import pbl_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic empty,
  input logic pop,
  input logic hit_o,
  input logic bypass_o,
  input logic fill_needed_o,
  input logic writeback_needed_o
);

  a_hit_nofill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && hit_o |-> !fill_needed_o && !bypass_o) else $error("hit with fill");

  a_byp_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && bypass_o |-> !hit_o && !fill_needed_o && !writeback_needed_o)
    else $error("bypass mixed");

  a_wb_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && writeback_needed_o |-> fill_needed_o) else $error("writeback without fill");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty) else $error("result dropped");

endmodule

bind page_buffer_pool_lru pbl_checker u_chk (.*);
